[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file u8s_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted (active-low reset).
`define U8S_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("u8s assertion failed");

// Clocked assertion that also holds through reset.
`define U8S_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("u8s assertion failed");

`endif

[rtl/u8s_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_pkg
// Shared types, constants and UTF-8 helper functions for the scrubber.
// ----------------------------------------------------------------------------
package u8s_pkg;

    // Release limit per input transaction and the most items one can yield.
    localparam int unsigned MAX_RESULTS    = 10;
    localparam int unsigned MAX_STEP_ITEMS = 12;
    localparam int unsigned REL_W          = 4;

    // Queue depths
    localparam int unsigned CMD_Q_DEPTH  = 4;
    localparam int unsigned ITEM_Q_DEPTH = 16;
    localparam int unsigned REL_Q_DEPTH  = 4;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FIELD_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_ENABLE    = 2'd1;
    localparam logic [15:0] MAX_FIELD_BYTES_RST = 16'd1024;
    localparam logic        STRIP_ENABLE_RST    = 1'b1;

    // UTF-8 byte classes
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD_MIN    = 8'hC2;
    localparam logic [7:0] LEAD2_MAX   = 8'hDF;
    localparam logic [7:0] LEAD3_MAX   = 8'hEF;
    localparam logic [7:0] LEAD_MAX    = 8'hF4;
    localparam logic [7:0] CONT_MIN    = 8'h80;
    localparam logic [7:0] CONT_MAX    = 8'hBF;
    localparam logic [7:0] LEAD_E0     = 8'hE0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] LEAD_F0     = 8'hF0;
    localparam logic [7:0] LEAD_F4     = 8'hF4;
    localparam logic [7:0] E0_CONT_MIN = 8'hA0;
    localparam logic [7:0] ED_CONT_MAX = 8'h9F;
    localparam logic [7:0] F0_CONT_MIN = 8'h90;
    localparam logic [7:0] F4_CONT_MAX = 8'h8F;

    // U+FFFD, element 0 is sent first
    localparam logic [2:0][7:0] REPL = {8'hBD, 8'hBF, 8'hEF};
    localparam logic [2:0]      REPL_LEN = 3'd3;

    // Separator bytes removed when stripping
    localparam logic [7:0] SEP_UNIT   = 8'h1F;
    localparam logic [7:0] SEP_RECORD = 8'h1E;
    localparam logic [7:0] SEP_NUL    = 8'h00;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       field_end;
    } t_item;

    // One decoded input transaction: pre flush, middle char, end flush.
    typedef struct packed {
        logic [1:0]      pre_repl;
        logic            mid_seq;
        logic            mid_repl;
        logic [3:0][7:0] seq;
        logic [2:0]      seq_len;
        logic [1:0]      post_repl;
        logic            field_end;
    } t_cmd;

    function automatic logic cont_ok(input logic [7:0] lead, input logic first,
                                     input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = CONT_MIN;
        hi = CONT_MAX;
        if (first) begin
            if (lead == LEAD_E0) lo = E0_CONT_MIN;
            else if (lead == LEAD_ED) hi = ED_CONT_MAX;
            else if (lead == LEAD_F0) lo = F0_CONT_MIN;
            else if (lead == LEAD_F4) hi = F4_CONT_MAX;
        end
        return (b >= lo) && (b <= hi);
    endfunction

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if (b <= LEAD2_MAX) len = 3'd2;
        else if (b <= LEAD3_MAX) len = 3'd3;
        else len = 3'd4;
        return len;
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        return (b == SEP_UNIT) || (b == SEP_RECORD) || (b == SEP_NUL);
    endfunction

endpackage
`default_nettype wire

[rtl/u8s_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_in_if
// Raw byte channel into the scrubber.
// ----------------------------------------------------------------------------
interface u8s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       field_end;

    modport source (output valid, data_byte, byte_present, field_end, input ready);
    modport sink   (input valid, data_byte, byte_present, field_end, output ready);
endinterface
`default_nettype wire

[rtl/u8s_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_out_if
// Scrubbed byte channel out of the scrubber.
// ----------------------------------------------------------------------------
interface u8s_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_present;
    logic       out_field_end;
    logic       run_last;

    modport source (output valid, out_byte, out_present, out_field_end, run_last,
                    input ready);
    modport sink   (input valid, out_byte, out_present, out_field_end, run_last,
                    output ready);
endinterface
`default_nettype wire

[rtl/u8s_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_fifo
// Small register-based FIFO, first-word-fall-through read.
// ----------------------------------------------------------------------------
module u8s_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    n_wp;
    logic [AW-1:0]    n_rp;
    logic [CW-1:0]    n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

[rtl/u8s_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_front
// Strict UTF-8 decoder: one byte per cycle while the command queue has room;
// makes each transaction a command (replacements, one character, end flush).
// ----------------------------------------------------------------------------
module u8s_front (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    u8s_in_if.sink      i_in,
    output logic        o_cmd_push,
    output u8s_pkg::t_cmd o_cmd,
    input  wire logic   i_cmd_full
);
    logic [7:0] r_pend [0:2];
    logic [1:0] r_pcnt;
    logic [2:0] r_need;
    logic [7:0] n_pend [0:2];
    logic [1:0] n_pcnt;
    logic [2:0] n_need;
    logic       lead_go;
    logic [7:0] b;
    logic       accept;

    assign b          = i_in.data_byte;
    assign i_in.ready = !i_cmd_full;
    assign accept     = i_in.valid && !i_cmd_full;
    assign o_cmd_push = accept;

    always_comb begin
        n_pend  = r_pend;
        n_pcnt  = r_pcnt;
        n_need  = r_need;
        o_cmd   = '0;
        lead_go = 1'b0;
        o_cmd.field_end = i_in.field_end;

        if (i_in.byte_present) begin
            if (r_pcnt == 2'd0) begin
                lead_go = 1'b1;
            end else if (u8s_pkg::cont_ok(r_pend[0], r_pcnt == 2'd1, b)) begin
                if (({1'b0, r_pcnt} + 3'd1) >= r_need) begin
                    // sequence complete
                    o_cmd.mid_seq = 1'b1;
                    o_cmd.seq_len = {1'b0, r_pcnt} + 3'd1;
                    for (int i = 0; i < 3; i++) begin
                        if (2'(i) < r_pcnt) o_cmd.seq[i] = r_pend[i];
                    end
                    o_cmd.seq[r_pcnt] = b;
                    n_pcnt = 2'd0;
                    n_need = 3'd0;
                end else begin
                    n_pend[r_pcnt] = b;
                    n_pcnt = r_pcnt + 2'd1;
                end
            end else begin
                // broken sequence: flush what is buffered, rejudge this byte
                o_cmd.pre_repl = r_pcnt;
                n_pcnt  = 2'd0;
                n_need  = 3'd0;
                lead_go = 1'b1;
            end
        end

        if (lead_go) begin
            if (b < u8s_pkg::ASCII_LIMIT) begin
                o_cmd.mid_seq = 1'b1;
                o_cmd.seq_len = 3'd1;
                o_cmd.seq[0]  = b;
            end else if ((b >= u8s_pkg::LEAD_MIN) && (b <= u8s_pkg::LEAD_MAX)) begin
                n_need    = u8s_pkg::lead_len(b);
                n_pend[0] = b;
                n_pcnt    = 2'd1;
            end else begin
                o_cmd.mid_repl = 1'b1;
            end
        end

        if (i_in.field_end) begin
            o_cmd.post_repl = n_pcnt;
            n_pcnt = 2'd0;
            n_need = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= 2'd0;
            r_need <= 3'd0;
        end else if (accept) begin
            r_pcnt <= n_pcnt;
            r_need <= n_need;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
        end
    end

endmodule
`default_nettype wire

[rtl/u8s_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_back
// Command executor: walks each command one byte per cycle while the item queue
// has room, applies the byte budget per character and the separator strip,
// marks field end, and works out how many items each transaction releases.
// ----------------------------------------------------------------------------
module u8s_back #(
    parameter int unsigned ITEM_DEPTH = u8s_pkg::ITEM_Q_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [15:0]                i_max_field_bytes,
    input  wire logic                       i_strip_enable,
    input  wire u8s_pkg::t_cmd              i_cmd,
    input  wire logic                       i_cmd_empty,
    output logic                            o_cmd_pop,
    output logic                            o_item_push,
    output u8s_pkg::t_item                  o_item,
    input  wire logic                       i_item_full,
    output logic                            o_rel_push,
    output logic [u8s_pkg::REL_W-1:0]       o_rel,
    input  wire logic                       i_rel_full
);
    localparam int unsigned BACK_W = $clog2(ITEM_DEPTH + u8s_pkg::MAX_STEP_ITEMS + 1);

    typedef enum logic [2:0] {PH_IDLE, PH_PRE, PH_MID, PH_POST, PH_STEP} t_phase;

    t_phase          r_phase, n_phase;
    u8s_pkg::t_cmd   r_cmd, n_cmd;
    logic [1:0]      r_left, n_left;
    logic [1:0]      r_bidx, n_bidx;
    logic            r_keep, n_keep;
    logic [15:0]     r_count, n_count;
    u8s_pkg::t_item  r_hold, n_hold;
    logic            r_hold_v, n_hold_v;
    logic [3:0]      r_nstep, n_nstep;
    logic [BACK_W-1:0] r_back, n_back;

    logic            is_repl;
    logic [2:0]      char_len;
    logic [7:0]      cur_byte;
    logic [16:0]     sum;
    logic            start;
    logic            keep_now;
    logic            emit;
    logic            last_byte;
    logic            stall_b;
    logic            marker;
    logic            step_wr;
    u8s_pkg::t_item  step_item;
    logic [3:0]      step_items;
    logic [BACK_W-1:0] step_sum;
    logic [BACK_W-1:0] rel;
    logic            stall_s;
    logic            load;

    function automatic t_phase after_mid(input u8s_pkg::t_cmd c);
        return (c.post_repl != 2'd0) ? PH_POST : PH_STEP;
    endfunction

    function automatic t_phase after_pre(input u8s_pkg::t_cmd c);
        return (c.mid_seq || c.mid_repl) ? PH_MID : after_mid(c);
    endfunction

    function automatic t_phase first_phase(input u8s_pkg::t_cmd c);
        return (c.pre_repl != 2'd0) ? PH_PRE : after_pre(c);
    endfunction

    function automatic t_phase phase_after(input t_phase p, input u8s_pkg::t_cmd c);
        t_phase q;
        priority if (p == PH_PRE) q = after_pre(c);
        else if (p == PH_MID) q = after_mid(c);
        else q = PH_STEP;
        return q;
    endfunction

    function automatic logic [1:0] left_for(input t_phase p, input u8s_pkg::t_cmd c);
        logic [1:0] l;
        priority if (p == PH_PRE) l = c.pre_repl;
        else if (p == PH_POST) l = c.post_repl;
        else l = 2'd1;
        return l;
    endfunction

    // current character
    assign is_repl   = (r_phase != PH_MID) || r_cmd.mid_repl;
    assign char_len  = is_repl ? u8s_pkg::REPL_LEN : r_cmd.seq_len;
    assign cur_byte  = is_repl ? u8s_pkg::REPL[r_bidx] : r_cmd.seq[r_bidx];
    assign sum       = {1'b0, r_count} + {14'b0, char_len};
    assign start     = (r_bidx == 2'd0);
    // budget decided once per character, on its first byte
    assign keep_now  = start ? (sum <= {1'b0, i_max_field_bytes}) : r_keep;
    assign emit      = keep_now && !(i_strip_enable && u8s_pkg::is_sep(cur_byte));
    assign last_byte = !keep_now || (({1'b0, r_bidx} + 3'd1) == char_len);
    assign stall_b   = emit && r_hold_v && i_item_full;

    // transaction end
    assign marker     = r_cmd.field_end && (r_nstep == 4'd0);
    assign step_wr    = r_hold_v || marker;
    assign step_items = r_nstep + {3'b0, marker};
    assign step_sum   = r_back + BACK_W'(step_items);
    assign rel        = (step_sum > BACK_W'(u8s_pkg::MAX_RESULTS)) ?
                        BACK_W'(u8s_pkg::MAX_RESULTS) : step_sum;
    assign stall_s    = (step_wr && i_item_full) || ((rel != '0) && i_rel_full);

    always_comb begin
        step_item = r_hold;
        if (marker) begin
            step_item = '{data: 8'h00, present: 1'b0, field_end: 1'b1};
        end else begin
            step_item.field_end = r_cmd.field_end;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_left   = r_left;
        n_bidx   = r_bidx;
        n_keep   = r_keep;
        n_count  = r_count;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        n_nstep  = r_nstep;
        n_back   = r_back;
        o_cmd_pop   = 1'b0;
        o_item_push = 1'b0;
        o_item      = r_hold;
        o_rel_push  = 1'b0;
        o_rel       = rel[u8s_pkg::REL_W-1:0];
        load        = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                load = !i_cmd_empty;
            end
            PH_PRE, PH_MID, PH_POST: begin
                if (!stall_b) begin
                    if (start) begin
                        n_count = sum[16] ? 16'hFFFF : sum[15:0];
                        n_keep  = keep_now;
                    end
                    if (emit) begin
                        // previous item goes out, this one waits for its end flag
                        o_item_push = r_hold_v;
                        n_hold   = '{data: cur_byte, present: 1'b1, field_end: 1'b0};
                        n_hold_v = 1'b1;
                        n_nstep  = r_nstep + 4'd1;
                    end
                    if (last_byte) begin
                        n_bidx = 2'd0;
                        if ((r_phase != PH_MID) && (r_left > 2'd1)) begin
                            n_left = r_left - 2'd1;
                        end else begin
                            n_phase = phase_after(r_phase, r_cmd);
                            n_left  = left_for(n_phase, r_cmd);
                        end
                    end else begin
                        n_bidx = r_bidx + 2'd1;
                    end
                end
            end
            PH_STEP: begin
                if (!stall_s) begin
                    o_item_push = step_wr;
                    o_item      = step_item;
                    o_rel_push  = (rel != '0);
                    n_back      = step_sum - rel;
                    n_nstep     = 4'd0;
                    n_hold_v    = 1'b0;
                    if (r_cmd.field_end) n_count = 16'd0;
                    if (!i_cmd_empty) load = 1'b1;
                    else n_phase = PH_IDLE;
                end
            end
        endcase

        if (load) begin
            o_cmd_pop = 1'b1;
            n_cmd     = i_cmd;
            n_phase   = first_phase(i_cmd);
            n_left    = left_for(n_phase, i_cmd);
            n_bidx    = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_left   <= 2'd0;
            r_bidx   <= 2'd0;
            r_keep   <= 1'b0;
            r_count  <= 16'd0;
            r_hold_v <= 1'b0;
            r_nstep  <= 4'd0;
            r_back   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_left   <= n_left;
            r_bidx   <= n_bidx;
            r_keep   <= n_keep;
            r_count  <= n_count;
            r_hold   <= n_hold;
            r_hold_v <= n_hold_v;
            r_nstep  <= n_nstep;
            r_back   <= n_back;
        end
    end

endmodule
`default_nettype wire

[rtl/u8s_drain.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_drain
// Output stage: sends released items and flags the last one of each
// transaction's release.
// ----------------------------------------------------------------------------
module u8s_drain (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire u8s_pkg::t_item         i_item,
    input  wire logic                   i_item_empty,
    output logic                        o_item_pop,
    input  wire logic [u8s_pkg::REL_W-1:0] i_rel,
    input  wire logic                   i_rel_empty,
    output logic                        o_rel_pop,
    u8s_out_if.source                   o_out
);
    logic [u8s_pkg::REL_W-1:0] r_cnt;
    logic                      last;
    logic                      fire;

    // a queued release count guarantees its items are already queued
    assign o_out.valid         = !i_rel_empty && !i_item_empty;
    assign o_out.out_byte      = i_item.data;
    assign o_out.out_present   = i_item.present;
    assign o_out.out_field_end = i_item.field_end;
    assign last                = ((r_cnt + 1'b1) == i_rel);
    assign o_out.run_last      = last;
    assign fire                = o_out.valid && o_out.ready;
    assign o_item_pop          = fire;
    assign o_rel_pop           = fire && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (fire) begin
            r_cnt <= last ? '0 : r_cnt + 1'b1;
        end
    end

endmodule
`default_nettype wire

[rtl/utf8_scrub_clamp_strip.sv]
// Throughput: input every cycle while the command queue has room. The executor
// walks each byte of a kept character, passes a character over budget as a
// whole and closes each transaction in a step of its own.
// Reset: synchronous active-low; clears all queues, decoder state and byte
// budget, and loads max_field_bytes = 1024 and strip_enable = 1.
// ----------------------------------------------------------------------------
// utf8_scrub_clamp_strip
// Strict UTF-8 scrubber with byte budget and separator stripping: decoder,
// command queue, executor, item and release queues, output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module utf8_scrub_clamp_strip #(
    parameter int unsigned CMD_DEPTH  = u8s_pkg::CMD_Q_DEPTH,
    parameter int unsigned ITEM_DEPTH = u8s_pkg::ITEM_Q_DEPTH,
    parameter int unsigned REL_DEPTH  = u8s_pkg::REL_Q_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    u8s_in_if.sink                                i_in,
    u8s_out_if.source                             o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [u8s_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [u8s_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    logic [15:0] r_max_field_bytes;
    logic        r_strip_enable;

    u8s_pkg::t_cmd  cmd_w, cmd_r;
    logic           cmd_push, cmd_pop, cmd_full, cmd_empty;
    u8s_pkg::t_item item_w, item_r;
    logic           item_push, item_pop, item_full, item_empty;
    logic [u8s_pkg::REL_W-1:0] rel_w, rel_r;
    logic           rel_push, rel_pop, rel_full, rel_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_field_bytes <= u8s_pkg::MAX_FIELD_BYTES_RST;
            r_strip_enable    <= u8s_pkg::STRIP_ENABLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                u8s_pkg::REG_MAX_FIELD_BYTES: r_max_field_bytes <= i_cfg_wdata[15:0];
                u8s_pkg::REG_STRIP_ENABLE:    r_strip_enable    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    u8s_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_w),
        .i_cmd_full (cmd_full)
    );

    u8s_fifo #(
        .WIDTH ($bits(u8s_pkg::t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (cmd_w),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_r),
        .o_full  (cmd_full),
        .o_empty (cmd_empty)
    );

    u8s_back #(
        .ITEM_DEPTH (ITEM_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_max_field_bytes (r_max_field_bytes),
        .i_strip_enable    (r_strip_enable),
        .i_cmd             (cmd_r),
        .i_cmd_empty       (cmd_empty),
        .o_cmd_pop         (cmd_pop),
        .o_item_push       (item_push),
        .o_item            (item_w),
        .i_item_full       (item_full),
        .o_rel_push        (rel_push),
        .o_rel             (rel_w),
        .i_rel_full        (rel_full)
    );

    u8s_fifo #(
        .WIDTH ($bits(u8s_pkg::t_item)),
        .DEPTH (ITEM_DEPTH)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_push),
        .i_wdata (item_w),
        .i_pop   (item_pop),
        .o_rdata (item_r),
        .o_full  (item_full),
        .o_empty (item_empty)
    );

    u8s_fifo #(
        .WIDTH (u8s_pkg::REL_W),
        .DEPTH (REL_DEPTH)
    ) u_rel_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rel_push),
        .i_wdata (rel_w),
        .i_pop   (rel_pop),
        .o_rdata (rel_r),
        .o_full  (rel_full),
        .o_empty (rel_empty)
    );

    u8s_drain u_drain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_r),
        .i_item_empty (item_empty),
        .o_item_pop   (item_pop),
        .i_rel        (rel_r),
        .i_rel_empty  (rel_empty),
        .o_rel_pop    (rel_pop),
        .o_out        (o_out)
    );

endmodule
`default_nettype wire

[rtl/u8s_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_checker
// Port-level checks on the scrubber output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8s_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_present,
    input wire logic       i_out_field_end,
    input wire logic       i_run_last
);

    // an item with no byte is only ever the empty end-of-field marker
    `U8S_ASSERT(a_marker_form, i_clk, i_rst_n, (i_out_valid && !i_out_present) |-> (i_out_field_end && (i_out_byte == 8'h00)))

    // a stalled transaction keeps its payload, including the release flag
    `U8S_ASSERT(a_stall_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte) && $stable(i_out_present) && $stable(i_out_field_end) && $stable(i_run_last)))

    // queues come out of reset empty
    `U8S_ASSERT_ALWAYS(a_reset_empty, i_clk, (!i_rst_n) |=> !i_out_valid)

endmodule

bind utf8_scrub_clamp_strip u8s_checker u_u8s_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_byte      (o_out.out_byte),
    .i_out_present   (o_out.out_present),
    .i_out_field_end (o_out.out_field_end),
    .i_run_last      (o_out.run_last)
);
`default_nettype wire

[sim/utf8_scrub_clamp_strip_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_scrub_clamp_strip_test
// Feeds raw field bytes through the scrubber under random bursts and output
// stalls. An in-bench predictor runs strict UTF-8 checking, the byte budget
// and separator stripping on every accepted transaction. Every output
// transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_scrub_clamp_strip_test;

    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned PHASE_ITEMS   = 38;
    localparam logic [u8s_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [3:0][7:0] REPL_SEQ = {8'h00, u8s_pkg::REPL};
    localparam logic [15:0] COUNT_SAT = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       field_end;
        logic       run_last;
    } t_scrub_out;

    typedef enum logic [1:0] {STALL_NONE, STALL_THIRDS, STALL_COIN, STALL_BURSTS} t_stall_mode;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [u8s_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [u8s_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    u8s_in_if  in_ch ();
    u8s_out_if out_ch ();

    utf8_scrub_clamp_strip dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // stimulus and expectations
    u8s_pkg::t_item raw_q[$];
    u8s_pkg::t_item drive_item;
    t_scrub_out     scrub_expect_q[$];
    u8s_pkg::t_item held_q[$];
    u8s_pkg::t_item stage_q[$];

    // predictor state
    logic [7:0]  lead_buf[3];
    logic [1:0]  lead_cnt;
    logic [2:0]  seq_need;
    logic [15:0] budget_used;
    logic [15:0] byte_budget;
    logic        strip_on;

    int          err_count   = 0;
    int unsigned cycle_count = 0;
    int          burst_left, gap_left;
    int          stall_left, mode_timer;
    t_stall_mode ready_mode;
    t_scrub_out  mon_got, mon_want;

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        err_count++;
    endtask

    // One character against the budget; kept only if it ends within it.
    function automatic void emit_char(input logic [3:0][7:0] seq, input int unsigned len);
        int unsigned total;
        int unsigned i;
        logic [7:0]  b;
        total = budget_used + len;
        if (total <= byte_budget) begin
            for (i = 0; i < len; i++) begin
                b = seq[i];
                if (!(strip_on && (b == u8s_pkg::SEP_UNIT || b == u8s_pkg::SEP_RECORD ||
                                   b == u8s_pkg::SEP_NUL)))
                    stage_q.insert(stage_q.size(), {b, 1'b1, 1'b0});
            end
        end
        budget_used = (total > COUNT_SAT) ? COUNT_SAT : 16'(total);
    endfunction

    function automatic void flush_leads();
        int i;
        for (i = 0; i < int'(lead_cnt); i++)
            emit_char(REPL_SEQ, 3);
        lead_cnt = '0;
        seq_need = '0;
    endfunction

    function automatic void take_lead(input logic [7:0] b);
        if (b < u8s_pkg::ASCII_LIMIT) begin
            emit_char({24'h0, b}, 1);
        end else if (b >= u8s_pkg::LEAD_MIN && b <= u8s_pkg::LEAD_MAX) begin
            seq_need = (b <= u8s_pkg::LEAD2_MAX) ? 3'd2 :
                       ((b <= u8s_pkg::LEAD3_MAX) ? 3'd3 : 3'd4);
            lead_buf[0] = b;
            lead_cnt = 2'd1;
        end else begin
            emit_char(REPL_SEQ, 3);
        end
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        logic [7:0]       lo, hi;
        logic [3:0][7:0]  seq;
        int               i, len;
        if (lead_cnt == 0) begin
            take_lead(b);
            return;
        end
        lo = u8s_pkg::CONT_MIN;
        hi = u8s_pkg::CONT_MAX;
        if (lead_cnt == 1) begin
            if (lead_buf[0] == u8s_pkg::LEAD_E0) lo = u8s_pkg::E0_CONT_MIN;
            else if (lead_buf[0] == u8s_pkg::LEAD_ED) hi = u8s_pkg::ED_CONT_MAX;
            else if (lead_buf[0] == u8s_pkg::LEAD_F0) lo = u8s_pkg::F0_CONT_MIN;
            else if (lead_buf[0] == u8s_pkg::LEAD_F4) hi = u8s_pkg::F4_CONT_MAX;
        end
        if (b >= lo && b <= hi) begin
            len = int'(lead_cnt) + 1;
            if (len >= int'(seq_need)) begin
                seq = '0;
                for (i = 0; i < int'(lead_cnt); i++)
                    seq[i] = lead_buf[i];
                seq[lead_cnt] = b;
                lead_cnt = '0;
                seq_need = '0;
                emit_char(seq, len);
            end else begin
                lead_buf[lead_cnt] = b;
                lead_cnt = lead_cnt + 2'd1;
            end
        end else begin
            // broken sequence: flush what is buffered, judge b as a new lead
            flush_leads();
            take_lead(b);
        end
    endfunction

    function automatic void scrub_step(input u8s_pkg::t_item it);
        int unsigned first_new, n, i;
        t_scrub_out  r;
        stage_q = held_q;
        held_q.delete();
        first_new = stage_q.size();
        if (it.present) take_byte(it.data);
        if (it.field_end) begin
            flush_leads();
            if (stage_q.size() <= first_new)
                stage_q.insert(stage_q.size(), {8'h00, 1'b0, 1'b0});
            stage_q[stage_q.size() - 1].field_end = 1'b1;
            budget_used = '0;
        end
        n = (stage_q.size() < u8s_pkg::MAX_RESULTS) ? stage_q.size() : u8s_pkg::MAX_RESULTS;
        for (i = 0; i < stage_q.size(); i++) begin
            if (i < n) begin
                r = {stage_q[i].data, stage_q[i].present, stage_q[i].field_end, i + 1 == n};
                scrub_expect_q.insert(scrub_expect_q.size(), r);
            end else begin
                held_q.insert(held_q.size(), stage_q[i]);
            end
        end
    endfunction

    function automatic void put(input logic [7:0] b, input logic present, input logic fe);
        raw_q.insert(raw_q.size(), {b, present, fe});
    endfunction

    // One character, mostly well formed; some noise and broken sequences.
    function automatic int gen_char();
        int              kind, len, pick, cut, i;
        logic            broken;
        logic [7:0]      lead, lo, hi;
        logic [3:0][7:0] seq;
        seq = '0;
        kind = $urandom_range(0, 11);
        broken = (kind >= 10);
        if (broken) kind = $urandom_range(4, 8);
        if (kind <= 3) begin
            len = 1;
            if ($urandom_range(0, 3) == 0) begin
                pick = $urandom_range(0, 2);
                seq[0] = (pick == 0) ? u8s_pkg::SEP_UNIT :
                         ((pick == 1) ? u8s_pkg::SEP_RECORD : u8s_pkg::SEP_NUL);
            end else begin
                seq[0] = 8'($urandom_range(0, 127));
            end
        end else if (kind == 9) begin
            len = 1;
            seq[0] = 8'($urandom_range(0, 255));
        end else begin
            len = (kind == 4) ? 2 : ((kind <= 6) ? 3 : 4);
            pick = $urandom_range(0, 3);
            if (len == 2) lead = 8'($urandom_range(8'hC2, 8'hDF));
            else if (len == 3)
                lead = (pick == 0) ? u8s_pkg::LEAD_E0 : ((pick == 1) ? u8s_pkg::LEAD_ED :
                       8'($urandom_range(8'hE1, 8'hEF)));
            else
                lead = (pick == 0) ? u8s_pkg::LEAD_F0 : ((pick == 1) ? u8s_pkg::LEAD_F4 :
                       8'($urandom_range(8'hF0, 8'hF4)));
            lo = u8s_pkg::CONT_MIN;
            hi = u8s_pkg::CONT_MAX;
            if (lead == u8s_pkg::LEAD_E0) lo = u8s_pkg::E0_CONT_MIN;
            else if (lead == u8s_pkg::LEAD_ED) hi = u8s_pkg::ED_CONT_MAX;
            else if (lead == u8s_pkg::LEAD_F0) lo = u8s_pkg::F0_CONT_MIN;
            else if (lead == u8s_pkg::LEAD_F4) hi = u8s_pkg::F4_CONT_MAX;
            seq[0] = lead;
            seq[1] = 8'($urandom_range(lo, hi));
            for (i = 2; i < len; i++)
                seq[i] = 8'($urandom_range(8'h80, 8'hBF));
        end
        if (broken) begin
            cut = $urandom_range(1, len - 1);
            if ($urandom_range(0, 1) == 0) len = cut;
            else seq[cut] = 8'($urandom_range(0, 255));
        end
        for (i = 0; i < len; i++)
            put(seq[i], 1'b1, 1'b0);
        return len;
    endfunction

    function automatic int gen_field();
        int chars, count, i;
        count = 0;
        // ignored item, not counted
        if ($urandom_range(0, 9) == 0) put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        chars = $urandom_range(0, 8);
        for (i = 0; i < chars; i++)
            count += gen_char();
        if (count > 0 && $urandom_range(0, 2) != 0) begin
            raw_q[raw_q.size() - 1].field_end = 1'b1;
        end else begin
            put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            count++;
        end
        return count;
    endfunction

    task automatic write_reg(input logic [u8s_pkg::CFG_IDX_W-1:0] idx,
                             input logic [u8s_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == u8s_pkg::REG_MAX_FIELD_BYTES) byte_budget = value;
        else if (idx == u8s_pkg::REG_STRIP_ENABLE) strip_on = value[0];
    endtask

    // Wait for the block to go idle; results held past the per-transaction
    // limit are released with an empty transaction.
    task automatic settle();
        do begin
            while (raw_q.size() != 0 || in_ch.valid || scrub_expect_q.size() != 0)
                @(negedge i_clk);
            if (held_q.size() != 0) put(8'h00, 1'b0, 1'b0);
        end while (held_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) scrub_step(drive_item);
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (raw_q.size() > 0) begin
                    drive_item = raw_q.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.data_byte    <= drive_item.data;
                    in_ch.byte_present <= drive_item.present;
                    in_ch.field_end    <= drive_item.field_end;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
            mode_timer = 0;
            ready_mode = STALL_NONE;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                mon_got = {out_ch.out_byte, out_ch.out_present, out_ch.out_field_end,
                           out_ch.run_last};
                if (scrub_expect_q.size() == 0) begin
                    report_mismatch("unexpected transaction, out_byte", 0, mon_got.data);
                end else begin
                    mon_want = scrub_expect_q.pop_front();
                    if (mon_got.data != mon_want.data)
                        report_mismatch("out_byte", mon_want.data, mon_got.data);
                    if (mon_got.present != mon_want.present)
                        report_mismatch("out_present", mon_want.present, mon_got.present);
                    if (mon_got.field_end != mon_want.field_end)
                        report_mismatch("out_field_end", mon_want.field_end,
                                        mon_got.field_end);
                    if (mon_got.run_last != mon_want.run_last)
                        report_mismatch("run_last", mon_want.run_last, mon_got.run_last);
                end
            end
            mode_timer++;
            if (mode_timer >= 97) begin
                mode_timer = 0;
                ready_mode = t_stall_mode'($urandom_range(0, 3));
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (ready_mode)
                    STALL_NONE:   out_ch.ready <= 1'b1;
                    STALL_THIRDS: out_ch.ready <= (mode_timer % 3 != 0);
                    STALL_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                    default: begin
                        out_ch.ready <= 1'b1;
                        if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("utf8_scrub_clamp_strip_test: done, errors");
            $finish;
        end
    end

    initial begin
        int p, count;
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = 8'h00;
        in_ch.byte_present = 1'b0;
        in_ch.field_end    = 1'b0;
        out_ch.ready       = 1'b0;
        lead_buf    = '{default: 8'h00};
        lead_cnt    = '0;
        seq_need    = '0;
        budget_used = '0;
        byte_budget = u8s_pkg::MAX_FIELD_BYTES_RST;
        strip_on    = u8s_pkg::STRIP_ENABLE_RST;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: ASCII, separators, bounded leads, surrogate, too-high plane
        put(8'h41, 1'b1, 1'b0);
        put(8'h00, 1'b1, 1'b0);
        put(8'h1F, 1'b1, 1'b0);
        put(8'h1E, 1'b1, 1'b0);
        put(8'h7F, 1'b1, 1'b0);
        put(8'h80, 1'b1, 1'b0);
        put(8'hE0, 1'b1, 1'b0);
        put(8'hA0, 1'b1, 1'b0);
        put(8'h80, 1'b1, 1'b0);
        put(8'hED, 1'b1, 1'b0);
        put(8'hA0, 1'b1, 1'b0);
        put(8'hF4, 1'b1, 1'b0);
        put(8'h8F, 1'b1, 1'b0);
        put(8'hBF, 1'b1, 1'b0);
        put(8'hBF, 1'b1, 1'b0);
        put(8'hF4, 1'b1, 1'b0);
        put(8'h90, 1'b1, 1'b0);
        // twelve bytes from one transaction; two are held over
        put(8'hF1, 1'b1, 1'b0);
        put(8'h80, 1'b1, 1'b0);
        put(8'h80, 1'b1, 1'b0);
        put(8'hFF, 1'b1, 1'b0);
        put(8'h5A, 1'b0, 1'b0);
        // pending bytes flushed by a marker-only end, then an empty field
        put(8'hE2, 1'b1, 1'b0);
        put(8'h82, 1'b1, 1'b0);
        put(8'hA5, 1'b0, 1'b1);
        put(8'hFF, 1'b0, 1'b1);
        settle();

        // zero budget, no stripping: only the end marker survives
        write_reg(u8s_pkg::REG_MAX_FIELD_BYTES, 16'h0000);
        write_reg(u8s_pkg::REG_STRIP_ENABLE, 16'h0000);
        put(8'h41, 1'b1, 1'b0);
        put(8'h00, 1'b1, 1'b0);
        put(8'hE2, 1'b1, 1'b0);
        put(8'h82, 1'b1, 1'b0);
        put(8'hAC, 1'b1, 1'b0);
        put(8'h00, 1'b0, 1'b1);
        settle();

        // cut at a character boundary; spare index must be ignored
        write_reg(u8s_pkg::REG_MAX_FIELD_BYTES, 16'd5);
        write_reg(REG_SPARE, 16'hFFFF);
        put(8'h41, 1'b1, 1'b0);
        put(8'h00, 1'b1, 1'b0);
        put(8'hE2, 1'b1, 1'b0);
        put(8'h82, 1'b1, 1'b0);
        put(8'hAC, 1'b1, 1'b0);
        put(8'h42, 1'b1, 1'b0);
        put(8'h43, 1'b1, 1'b1);
        put(8'h41, 1'b1, 1'b0);
        put(8'h1E, 1'b1, 1'b0);
        settle();
        // budget lowered in the middle of a field
        write_reg(u8s_pkg::REG_MAX_FIELD_BYTES, 16'd3);
        put(8'h43, 1'b1, 1'b0);
        put(8'h44, 1'b1, 1'b0);
        put(8'h00, 1'b0, 1'b1);
        settle();

        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    write_reg(u8s_pkg::REG_MAX_FIELD_BYTES, 16'hFFFF);
                    write_reg(u8s_pkg::REG_STRIP_ENABLE, 16'h0000);
                end
                1: begin
                    write_reg(u8s_pkg::REG_MAX_FIELD_BYTES, 16'($urandom_range(0, 12)));
                    write_reg(u8s_pkg::REG_STRIP_ENABLE, 16'h0001);
                end
                2: begin
                    write_reg(u8s_pkg::REG_MAX_FIELD_BYTES, 16'($urandom_range(3, 20)));
                    write_reg(u8s_pkg::REG_STRIP_ENABLE, 16'hFFFE);
                end
                default: begin
                    write_reg(u8s_pkg::REG_MAX_FIELD_BYTES, u8s_pkg::MAX_FIELD_BYTES_RST);
                    write_reg(u8s_pkg::REG_STRIP_ENABLE, 16'h0001);
                    write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
                end
            endcase
            count = 0;
            while (count < PHASE_ITEMS)
                count += gen_field();
            settle();
        end

        if (err_count == 0)
            $display("utf8_scrub_clamp_strip_test: done, clean");
        else
            $display("utf8_scrub_clamp_strip_test: done, errors");
        $finish;
    end

endmodule
